// ----- rtl/query_text_normalizer_unit_macros.svh -----
// Assertion helpers shared by the RTL files.
`ifndef QUERY_TEXT_NORMALIZER_UNIT_MACROS_SVH
`define QUERY_TEXT_NORMALIZER_UNIT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define QTN_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define QTN_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/qtn_pkg.sv -----
`default_nettype none

package qtn_pkg;

    localparam int UNIT_W  = 16;
    localparam int LEN_W   = 12;
    localparam int CNT_W   = LEN_W + 1;

    localparam logic [LEN_W-1:0]  MAX_LEN_RESET = 12'd200;
    localparam logic [UNIT_W-1:0] SPACE_UNIT    = 16'h0020;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CONTROL  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_TOO_LONG = 2'd3
    } qtn_status_t;

    typedef struct packed {
        logic [UNIT_W-1:0] unit;
        logic              has_unit;
        logic              last_unit;
        logic              is_ctrl;
        logic              is_ws;
    } qtn_in_t;

    typedef struct packed {
        qtn_status_t       query_status;
        logic              end_of_query;
        logic              unit_valid;
        logic [UNIT_W-1:0] out_unit;
    } qtn_item_t;

    function automatic logic is_control(input logic [UNIT_W-1:0] c);
        return (c < 16'h0020) || (c == 16'h007f) ||
               ((c >= 16'h0080) && (c <= 16'h009f));
    endfunction

    function automatic logic is_space(input logic [UNIT_W-1:0] c);
        return ((c >= 16'h0009) && (c <= 16'h000d)) || (c == 16'h0020) ||
               (c == 16'h0085) || (c == 16'h00a0) || (c == 16'h1680) ||
               ((c >= 16'h2000) && (c <= 16'h200a)) || (c == 16'h2028) ||
               (c == 16'h2029) || (c == 16'h202f) || (c == 16'h205f) ||
               (c == 16'h3000);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/qtn_in_reg.sv -----
`default_nettype none

module qtn_in_reg (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [qtn_pkg::UNIT_W-1:0] s_tdata,
    input  wire logic                       s_tuser,
    input  wire logic                       s_tlast,
    input  wire logic                       take,
    output logic                            item_vld,
    output qtn_pkg::qtn_in_t                item
);
    import qtn_pkg::*;

    logic    vld_reg;
    logic    vld_next;
    qtn_in_t item_reg;
    logic    load;

    assign s_tready = !vld_reg || take;
    assign load     = s_tvalid && s_tready;

    always_comb
    begin
        vld_next = vld_reg;
        if (load)
        begin
            vld_next = 1'b1;
        end
        else if (take)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // classify at capture so the next stage only does counting
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.unit      <= s_tdata;
            item_reg.has_unit  <= s_tuser;
            item_reg.last_unit <= s_tlast;
            item_reg.is_ctrl   <= is_control(s_tdata);
            item_reg.is_ws     <= is_space(s_tdata);
        end
    end

    assign item_vld = vld_reg;
    assign item     = item_reg;

endmodule

`default_nettype wire

// ----- rtl/qtn_norm.sv -----
`default_nettype none

`include "query_text_normalizer_unit_macros.svh"

module qtn_norm (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_wen,
    input  wire logic [qtn_pkg::LEN_W-1:0] cfg_wdata,
    input  wire logic                      item_vld,
    input  wire qtn_pkg::qtn_in_t          item,
    input  wire logic                      fifo_room,
    output logic                           take,
    output logic [1:0]                     push_cnt,
    output qtn_pkg::qtn_item_t             e0,
    output qtn_pkg::qtn_item_t             e1
);
    import qtn_pkg::*;

    logic [LEN_W-1:0] max_len_reg;
    logic             sp_reg;
    logic             sp_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             ctrl_reg;
    logic             ctrl_next;

    logic [CNT_W-1:0] lim;
    logic [CNT_W-1:0] cnt1;
    logic [CNT_W-1:0] cnt2;
    logic             emit_sp;
    logic             emit_c;
    qtn_status_t      status;
    logic [1:0]       n_out;

    assign take = item_vld && fifo_room;
    assign lim  = {1'b0, max_len_reg};

    always_comb
    begin
        ctrl_next = ctrl_reg;
        sp_next   = sp_reg;
        cnt1      = cnt_reg;
        cnt2      = cnt_reg;
        emit_sp   = 1'b0;
        emit_c    = 1'b0;
        if (item.has_unit)
        begin
            if (item.is_ctrl)
            begin
                ctrl_next = 1'b1;
            end
            else if (!ctrl_reg)
            begin
                if (item.is_ws)
                begin
                    sp_next = (cnt_reg != '0);
                end
                else
                begin
                    emit_sp = sp_reg && (cnt_reg < lim);
                    cnt1    = (sp_reg && (cnt_reg <= lim)) ? cnt_reg + CNT_W'(1) : cnt_reg;
                    emit_c  = (cnt1 < lim);
                    cnt2    = (cnt1 <= lim) ? cnt1 + CNT_W'(1) : cnt1;
                    sp_next = 1'b0;
                end
            end
        end
        cnt_next = cnt2;
        if (item.last_unit)
        begin
            ctrl_next = 1'b0;
            sp_next   = 1'b0;
            cnt_next  = '0;
        end
    end

    always_comb
    begin
        if (ctrl_next && !item.last_unit)
        begin
            status = ST_CONTROL;
        end
        else if (ctrl_reg || (item.has_unit && item.is_ctrl))
        begin
            status = ST_CONTROL;
        end
        else if (cnt2 == '0)
        begin
            status = ST_EMPTY;
        end
        else if (cnt2 > lim)
        begin
            status = ST_TOO_LONG;
        end
        else
        begin
            status = ST_OK;
        end
    end

    always_comb
    begin
        e0       = '0;
        e1       = '0;
        n_out    = {1'b0, emit_sp} + {1'b0, emit_c};
        e0.query_status = ST_OK;
        e1.query_status = ST_OK;
        if (emit_sp)
        begin
            e0.unit_valid = 1'b1;
            e0.out_unit   = SPACE_UNIT;
            e1.unit_valid = 1'b1;
            e1.out_unit   = item.unit;
        end
        else if (emit_c)
        begin
            e0.unit_valid = 1'b1;
            e0.out_unit   = item.unit;
        end
        if (item.last_unit)
        begin
            case (n_out)
                2'd0:
                begin
                    e0.end_of_query = 1'b1;
                    e0.query_status = status;
                    n_out           = 2'd1;
                end
                2'd1:
                begin
                    e0.end_of_query = 1'b1;
                    e0.query_status = status;
                end
                default:
                begin
                    e1.end_of_query = 1'b1;
                    e1.query_status = status;
                end
            endcase
        end
        push_cnt = take ? n_out : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
            sp_reg      <= 1'b0;
            cnt_reg     <= '0;
            ctrl_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                max_len_reg <= cfg_wdata;
            end
            if (take)
            begin
                sp_reg   <= sp_next;
                cnt_reg  <= cnt_next;
                ctrl_reg <= ctrl_next;
            end
        end
    end

    `QTN_ASSERT_NXT(a_clear_after_end, clk, rst_n, take && item.last_unit,
        (cnt_reg == '0) && !ctrl_reg && !sp_reg, "query state not cleared after end")
    `QTN_ASSERT_IMP(a_pair_starts_space, clk, rst_n, push_cnt == 2'd2,
        e0.unit_valid && (e0.out_unit == SPACE_UNIT) && !e0.end_of_query,
        "two results without a leading space")
    `QTN_ASSERT_IMP(a_no_unit_after_ctrl, clk, rst_n, take && ctrl_reg,
        !e0.unit_valid && (push_cnt != 2'd2), "unit emitted after control character")

endmodule

`default_nettype wire

// ----- rtl/qtn_out_fifo.sv -----
`default_nettype none

`include "query_text_normalizer_unit_macros.svh"

module qtn_out_fifo (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [1:0]                  push_cnt,
    input  wire qtn_pkg::qtn_item_t          e0,
    input  wire qtn_pkg::qtn_item_t          e1,
    output logic                             fifo_room,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [qtn_pkg::UNIT_W-1:0]       m_tdata,
    output logic [2:0]                       m_tuser,
    output logic                             m_tlast
);
    import qtn_pkg::*;

    qtn_item_t          mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_next;
    logic [FIFO_CW-1:0] count_reg;
    logic [FIFO_CW-1:0] count_next;
    logic               pop;
    qtn_item_t          head;

    assign pop         = m_tvalid && m_tready;
    assign fifo_room   = (count_reg <= FIFO_CW'(FIFO_DEPTH - 2));
    assign wr_ptr_next = wr_ptr_reg + FIFO_AW'(push_cnt);
    assign rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
    assign count_next  = count_reg + FIFO_CW'(push_cnt) - FIFO_CW'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem[wr_ptr_reg] <= e0;
        end
        if (push_cnt == 2'd2)
        begin
            mem[wr_ptr_reg + FIFO_AW'(1)] <= e1;
        end
    end

    assign head     = mem[rd_ptr_reg];
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = head.out_unit;
    assign m_tuser  = {head.query_status, head.unit_valid};
    assign m_tlast  = head.end_of_query;

    `QTN_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1,
        count_reg <= FIFO_CW'(FIFO_DEPTH), "result queue over capacity")
    `QTN_ASSERT_IMP(a_push_has_room, clk, rst_n, push_cnt != 2'd0,
        count_reg <= FIFO_CW'(FIFO_DEPTH - 2), "push into full result queue")
    `QTN_ASSERT_NXT(a_pop_only, clk, rst_n, pop && (push_cnt == 2'd0),
        count_reg == $past(count_reg) - FIFO_CW'(1), "pop did not drain queue")

endmodule

`default_nettype wire

// ----- rtl/query_text_normalizer_unit.sv -----
// Query text normalizer. Takes a raw query one UTF-16 code unit per request,
// drops leading and trailing whitespace and collapses each inner whitespace
// run into a single space (0x20). Normalized units leave as soon as they are
// known; the request that carries tlast holds the query status in
// m_tuser[2:1] (0 ok, 1 control character, 2 empty, 3 too long). On any
// error status discard the query's units. An input request with tuser low
// carries no unit and, without tlast, produces no output. One request enters
// per cycle while the result queue has room; a unit that ends a whitespace
// run yields two output requests, so the output side sets the rate to one
// result per cycle, through a four-entry result queue after a single
// registered classify/count stage; each request passes that register, then
// the queue. Write max_length (reset 200) through cfg_wen/cfg_wdata only between queries.
`default_nettype none

module query_text_normalizer_unit (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wen,
    input  wire logic [qtn_pkg::LEN_W-1:0]  cfg_wdata,   // max_length
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [qtn_pkg::UNIT_W-1:0] s_tdata,     // [15:0] code_unit
    input  wire logic                       s_tuser,     // [0] has_unit
    input  wire logic                       s_tlast,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [qtn_pkg::UNIT_W-1:0]      m_tdata,     // [15:0] out_unit
    output logic [2:0]                      m_tuser,     // [0] unit_valid, [2:1] query_status
    output logic                            m_tlast
);
    import qtn_pkg::*;

    logic       item_vld;
    qtn_in_t    item;
    logic       take;
    logic       fifo_room;
    logic [1:0] push_cnt;
    qtn_item_t  e0;
    qtn_item_t  e1;

    qtn_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .take     (take),
        .item_vld (item_vld),
        .item     (item)
    );

    qtn_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .item_vld  (item_vld),
        .item      (item),
        .fifo_room (fifo_room),
        .take      (take),
        .push_cnt  (push_cnt),
        .e0        (e0),
        .e1        (e1)
    );

    qtn_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .e0        (e0),
        .e1        (e1),
        .fifo_room (fifo_room),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

// ----- verif/query_text_normalizer_unit_tb.sv -----
`default_nettype none

module query_text_normalizer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qtn_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 20;

    class query_norm_scoreboard;
        logic [LEN_W-1:0] max_len;
        logic             space_pending;
        logic [CNT_W-1:0] emitted_count;
        logic             control_seen;
        qtn_item_t        expected_items[$];
        int               errors;

        function new();
            max_len = MAX_LEN_RESET;
            space_pending = 1'b0;
            emitted_count = '0;
            control_seen = 1'b0;
            errors = 0;
        endfunction

        function void set_max_length(logic [LEN_W-1:0] v);
            max_len = v;
        endfunction

        function int pending();
            return expected_items.size();
        endfunction

        function bit ctrl_unit(logic [UNIT_W-1:0] c);
            return c <= 16'h001f || c == 16'h007f || c inside {[16'h0080:16'h009f]};
        endfunction

        function bit ws_unit(logic [UNIT_W-1:0] c);
            return c inside {[16'h0009:16'h000d], 16'h0020, 16'h0085, 16'h00a0,
                             16'h1680, [16'h2000:16'h200a], 16'h2028, 16'h2029,
                             16'h202f, 16'h205f, 16'h3000};
        endfunction

        function bit count_unit();
            if (emitted_count < {1'b0, max_len})
            begin
                emitted_count++;
                return 1'b1;
            end
            if (emitted_count == {1'b0, max_len})
                emitted_count++;
            return 1'b0;
        endfunction

        function qtn_item_t make_item(logic [UNIT_W-1:0] u, logic v);
            qtn_item_t it;
            it.out_unit = u;
            it.unit_valid = v;
            it.end_of_query = 1'b0;
            it.query_status = ST_OK;
            return it;
        endfunction

        function void predict_request(logic [UNIT_W-1:0] c, logic has, logic last);
            qtn_item_t   made[$];
            qtn_status_t st;
            if (has)
            begin
                if (ctrl_unit(c))
                    control_seen = 1'b1;
                else if (!control_seen)
                begin
                    if (ws_unit(c))
                        space_pending = (emitted_count != '0);
                    else
                    begin
                        if (space_pending && count_unit())
                            made.push_back(make_item(SPACE_UNIT, 1'b1));
                        space_pending = 1'b0;
                        if (count_unit())
                            made.push_back(make_item(c, 1'b1));
                    end
                end
            end
            if (last)
            begin
                if (control_seen)
                    st = ST_CONTROL;
                else if (emitted_count == '0)
                    st = ST_EMPTY;
                else if (emitted_count > {1'b0, max_len})
                    st = ST_TOO_LONG;
                else
                    st = ST_OK;
                if (made.size() == 0)
                    made.push_back(make_item('0, 1'b0));
                made[made.size()-1].end_of_query = 1'b1;
                made[made.size()-1].query_status = st;
                space_pending = 1'b0;
                emitted_count = '0;
                control_seen = 1'b0;
            end
            foreach (made[i])
                expected_items.push_back(made[i]);
        endfunction

        task report_mismatch(string what, int got, int want);
            errors++;
            $display("%0t mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        endtask

        task check_result(logic [UNIT_W-1:0] u, logic v, logic e, qtn_status_t st);
            qtn_item_t want;
            if (expected_items.size() == 0)
            begin
                report_mismatch("unexpected result, out_unit", int'(u), 0);
                return;
            end
            want = expected_items.pop_front();
            if (u !== want.out_unit)
                report_mismatch("out_unit", int'(u), int'(want.out_unit));
            if (v !== want.unit_valid)
                report_mismatch("unit_valid", int'(v), int'(want.unit_valid));
            if (e !== want.end_of_query)
                report_mismatch("end_of_query", int'(e), int'(want.end_of_query));
            if (st !== want.query_status)
                report_mismatch("query_status", int'(st), int'(want.query_status));
        endtask
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wen;
    logic [LEN_W-1:0]     cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [UNIT_W-1:0]    s_tdata;
    logic                 s_tuser;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [UNIT_W-1:0]    m_tdata;
    logic [2:0]           m_tuser;
    logic                 m_tlast;

    query_norm_scoreboard norm_sb;
    int                   send_idle_pct;
    int                   recv_idle_pct;
    int                   hold_request;
    int                   hold_left;
    int                   cycle_count;

    query_text_normalizer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                norm_sb.check_result(m_tdata, m_tuser[0], m_tlast, qtn_status_t'(m_tuser[2:1]));
            if (s_tvalid && s_tready)
                norm_sb.predict_request(s_tdata, s_tuser, s_tlast);
        end
    end

    initial
    begin
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && hold_request != 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic send_request(input logic [UNIT_W-1:0] u, input logic h, input logic l);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= u;
        s_tuser  <= h;
        s_tlast  <= l;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (norm_sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_max_length(input logic [LEN_W-1:0] v);
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_wen <= 1'b0;
        norm_sb.set_max_length(v);
    endtask

    function automatic logic [UNIT_W-1:0] pick_unit();
        int bucket;
        bucket = $urandom_range(0, 99);
        if (bucket < 45)
            return UNIT_W'($urandom_range(16'h0021, 16'h007e));
        if (bucket < 65)
        begin
            case ($urandom_range(0, 8))
                0: return 16'h0020;
                1: return UNIT_W'($urandom_range(16'h0009, 16'h000d));
                2: return 16'h0085;
                3: return 16'h00a0;
                4: return 16'h1680;
                5: return UNIT_W'($urandom_range(16'h2000, 16'h200a));
                6: return UNIT_W'($urandom_range(16'h2028, 16'h2029));
                7: return ($urandom_range(0, 1) != 0) ? 16'h202f : 16'h205f;
                default: return 16'h3000;
            endcase
        end
        if (bucket < 68)
        begin
            case ($urandom_range(0, 2))
                0: return UNIT_W'($urandom_range(16'h0000, 16'h001f));
                1: return 16'h007f;
                default: return UNIT_W'($urandom_range(16'h0080, 16'h009f));
            endcase
        end
        if (bucket < 90)
            return UNIT_W'($urandom_range(0, 16'hffff));
        case ($urandom_range(0, 9))
            0: return 16'h0008;
            1: return 16'h000e;
            2: return 16'h001f;
            3: return 16'h00a1;
            4: return 16'h00ff;
            5: return 16'h1fff;
            6: return 16'h200b;
            7: return 16'h2030;
            8: return 16'h3001;
            default: return 16'hffff;
        endcase
    endfunction

    task automatic send_random_query(output int counted);
        int n;
        bit bare_end;
        counted = 0;
        if ($urandom_range(0, 99) < 4)
        begin
            send_request(UNIT_W'($urandom_range(0, 16'hffff)), 1'b0, 1'b1);
            counted = 1;
            return;
        end
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        bare_end = ($urandom_range(0, 6) == 0);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_request(UNIT_W'($urandom_range(0, 16'hffff)), 1'b0, 1'b0);
            send_request(pick_unit(), 1'b1, (i == n - 1) && !bare_end);
            counted++;
        end
        if (bare_end)
        begin
            send_request(UNIT_W'($urandom_range(0, 16'hffff)), 1'b0, 1'b1);
            counted++;
        end
    endtask

    task automatic run_phase(input int s_idle, input int r_idle, input logic [LEN_W-1:0] lim,
                             input int quota, input int hold);
        int sent;
        int got;
        wait_idle();
        write_max_length(lim);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        hold_request = hold;
        sent = 0;
        while (sent < quota)
        begin
            send_random_query(got);
            sent += got;
        end
    endtask

    initial
    begin
        norm_sb = new();
        cycle_count = 0;
        send_idle_pct = 11;
        recv_idle_pct = 76;
        hold_request = 0;
        rst_n     <= 1'b0;
        cfg_wen   <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        s_tlast   <= 1'b0;
        m_tready  <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(16'h0000, 1'b0, 1'b1);
        send_request(16'hbeef, 1'b0, 1'b0);
        send_request(16'h0020, 1'b1, 1'b0);
        send_request(16'h3000, 1'b1, 1'b0);
        send_request(16'h0048, 1'b1, 1'b0);
        send_request(16'h0009, 1'b1, 1'b0);
        send_request(16'h2028, 1'b1, 1'b0);
        send_request(16'h0069, 1'b1, 1'b1);
        send_request(16'hffff, 1'b1, 1'b0);
        send_request(16'h0020, 1'b1, 1'b0);
        send_request(16'hffff, 1'b0, 1'b1);
        send_request(16'h0085, 1'b1, 1'b0);
        send_request(16'h200a, 1'b1, 1'b1);
        send_request(16'h0078, 1'b1, 1'b0);
        send_request(16'h007f, 1'b1, 1'b0);
        send_request(16'h0079, 1'b1, 1'b1);
        send_request(16'h009f, 1'b1, 1'b1);
        send_request(16'h0000, 1'b1, 1'b1);
        send_request(16'h0080, 1'b1, 1'b0);
        send_request(16'h0041, 1'b1, 1'b1);

        wait_idle();
        write_max_length(12'd3);
        send_request(16'h0061, 1'b1, 1'b0);
        send_request(16'h0062, 1'b1, 1'b0);
        send_request(16'h0020, 1'b1, 1'b0);
        send_request(16'h0063, 1'b1, 1'b0);
        send_request(16'h0064, 1'b1, 1'b1);

        run_phase(11, 76, 12'd4095, 117, 0);
        run_phase(11, 76, 12'd12, 117, 0);
        run_phase(76, 11, 12'd1, 117, 0);
        run_phase(76, 11, 12'd5, 117, 0);
        run_phase(0, 0, 12'd200, 117, 400);
        run_phase(0, 0, 12'd30, 117, 0);

        wait_idle();
        if (norm_sb.pending() != 0)
            norm_sb.report_mismatch("results left over, count", norm_sb.pending(), 0);
        if (norm_sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
